// ===== hw/rtl/lcdseq_pkg.sv =====
`timescale 1ns / 1ps

package lcdseq_pkg;

    // request codes on the input stream
    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_CMD    = 2'd1,
        OP_CHAR   = 2'd2,
        OP_CURSOR = 2'd3
    } opcode_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY = 2'd2;

    // controller codes and timing
    localparam logic [7:0] FSET_8BIT   = 8'h38;
    localparam logic [7:0] FSET_4BIT   = 8'h28;
    localparam logic [7:0] CLEAR_CODE  = 8'h01;
    localparam logic [3:0] FSET_NIBBLE = 4'h2;
    localparam logic [6:0] INIT_HOLD   = 7'd2;
    localparam logic [6:0] NIB_GAP     = 7'd2;
    localparam logic [6:0] SETTLE_HOLD = 7'd101;

    // configuration seen by the sequencer
    typedef struct packed {
        logic       nibble_mode;
        logic [7:0] disp_code;
        logic [7:0] entry_code;
    } cfg_t;

    // one classified request
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] data;
    } job_t;

    // one pin step
    typedef struct packed {
        logic       rs;
        logic       en;
        logic [7:0] data;
        logic [6:0] hold;
        logic       last;
    } step_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PRE,
        B_NIB,
        B_BYTE
    } back_state_t;

endpackage

// ===== hw/rtl/lcdseq_front.sv =====
`timescale 1ns / 1ps

module lcdseq_front
    import lcdseq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic [31:0]          req_data,
    output job_t                 job,
    output cfg_t                 cfg
);

    logic       mode_reg;
    logic [7:0] disp_reg;
    logic [7:0] entry_reg;

    opcode_t    op;
    logic [7:0] value;
    logic [7:0] row_base;
    logic [6:0] column;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            disp_reg  <= 8'h0C;
            entry_reg <= 8'h06;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[0];
                CFG_DISP:  disp_reg  <= cfg_data;
                CFG_ENTRY: entry_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign cfg.nibble_mode = mode_reg;
    assign cfg.disp_code   = disp_reg;
    assign cfg.entry_code  = entry_reg;

    // field unpacking
    assign op       = opcode_t'(req_data[1:0]);
    assign value    = req_data[9:2];
    assign row_base = req_data[17:10];
    assign column   = req_data[24:18];

    // classify the request into init or a single byte
    always_comb
    begin
        job.is_init = 1'b0;
        job.rs      = 1'b0;
        job.data    = value;
        unique case (op)
            OP_INIT:   job.is_init = 1'b1;
            OP_CMD:    job.rs      = 1'b0;
            OP_CHAR:   job.rs      = 1'b1;
            OP_CURSOR: job.data    = 8'(row_base + {1'b0, column} - 8'd1);
            default:   job.is_init = 1'b0;
        endcase
    end

endmodule

// ===== hw/rtl/lcdseq_queue.sv =====
`timescale 1ns / 1ps

module lcdseq_queue
    import lcdseq_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic in_ready,
    input  logic pop,
    output logic out_valid,
    output job_t out_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = slots[rd_ptr_reg];

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/lcdseq_back.sv =====
`timescale 1ns / 1ps

module lcdseq_back
    import lcdseq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  q_valid,
    input  job_t  q_job,
    output logic  q_pop,
    output logic  out_valid,
    input  logic  out_ready,
    output step_t out_step
);

    back_state_t state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    logic [1:0]  idx_reg, idx_next;
    job_t        job_reg, job_next;
    logic        rs_reg, rs_next;
    logic        en_reg, en_next;
    logic [7:0]  data_reg, data_next;
    logic        out_valid_reg;
    step_t       out_step_reg;

    logic        adv;
    logic [7:0]  cur_byte;
    logic        cur_rs;
    logic [1:0]  extra;
    logic        byte_done;
    logic [6:0]  hold;
    logic        last;

    assign out_valid = out_valid_reg;
    assign out_step  = out_step_reg;

    // a step is produced when the sequencer is not idle and the output register is free or being emptied
    assign adv = (state_reg != B_IDLE) && (!out_valid_reg || out_ready);

    // byte being sent and its extra delay
    always_comb
    begin
        cur_byte = job_reg.data;
        cur_rs   = job_reg.rs;
        extra    = 2'd0;
        if (job_reg.is_init)
        begin
            cur_rs = 1'b0;
            extra  = 2'd1;
            case (idx_reg)
                2'd0:    cur_byte = cfg.nibble_mode ? FSET_4BIT : FSET_8BIT;
                2'd1:    cur_byte = cfg.disp_code;
                2'd2:
                begin
                    cur_byte = CLEAR_CODE;
                    extra    = 2'd2;
                end
                default: cur_byte = cfg.entry_code;
            endcase
        end
    end

    // step sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        job_next   = job_reg;
        rs_next    = rs_reg;
        en_next    = en_reg;
        data_next  = data_reg;
        hold       = 7'd1;
        last       = 1'b0;
        byte_done  = 1'b0;
        q_pop      = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    job_next   = q_job;
                    step_next  = '0;
                    idx_next   = '0;
                    state_next = q_job.is_init ? B_PRE : B_BYTE;
                end
            end
            B_PRE:
            begin
                hold = INIT_HOLD;
                if (adv)
                begin
                    state_next = cfg.nibble_mode ? B_NIB : B_BYTE;
                    step_next  = '0;
                end
            end
            B_NIB:
            begin
                case (step_reg)
                    3'd0:    rs_next = 1'b0;
                    3'd1:    data_next = {FSET_NIBBLE, data_reg[3:0]};
                    3'd2:    en_next = 1'b1;
                    default: en_next = 1'b0;
                endcase
                if (adv)
                begin
                    if (step_reg == 3'd3)
                    begin
                        state_next = B_BYTE;
                        step_next  = '0;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            B_BYTE:
            begin
                if (cfg.nibble_mode)
                begin
                    case (step_reg)
                        3'd0:    rs_next = cur_rs;
                        3'd1:
                        begin
                            data_next = {cur_byte[7:4], data_reg[3:0]};
                            en_next   = 1'b1;
                        end
                        3'd2:
                        begin
                            en_next = 1'b0;
                            hold    = NIB_GAP;
                        end
                        3'd3:    data_next = {cur_byte[3:0], data_reg[3:0]};
                        3'd4:    en_next = 1'b1;
                        default:
                        begin
                            en_next   = 1'b0;
                            byte_done = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    case (step_reg)
                        3'd0:    rs_next = cur_rs;
                        3'd1:    data_next = cur_byte;
                        3'd2:    en_next = 1'b1;
                        default:
                        begin
                            en_next   = 1'b0;
                            byte_done = 1'b1;
                        end
                    endcase
                end
                if (byte_done)
                begin
                    hold = SETTLE_HOLD + {5'd0, extra};
                    last = !job_reg.is_init || (idx_reg == 2'd3);
                end
                if (adv)
                begin
                    if (!byte_done)
                    begin
                        step_next = step_reg + 3'd1;
                    end
                    else if (last)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        step_next = '0;
                        idx_next  = idx_reg + 2'd1;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // control and pin state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            idx_reg       <= '0;
            rs_reg        <= 1'b0;
            en_reg        <= 1'b0;
            data_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            if (adv)
            begin
                rs_reg        <= rs_next;
                en_reg        <= en_next;
                data_reg      <= data_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // job and output payload
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (adv)
        begin
            out_step_reg.rs   <= rs_next;
            out_step_reg.en   <= en_next;
            out_step_reg.data <= data_next;
            out_step_reg.hold <= hold;
            out_step_reg.last <= last;
        end
    end

endmodule

// ===== hw/rtl/char_lcd_bus_sequencer.sv =====
`timescale 1ns / 1ps
// requests pass through the queue to the sequencer, and pin steps leave from a registered output
// throughput: one pin step per cycle while m_tready is high, with an idle state between requests
// a command or character is sequenced by the step counter, with a second nibble in 4-bit mode
// init sends a pre-delay step, a function-set nibble in 4-bit mode, then four command bytes
// reset: async active low, pin state registers low, config back to 8-bit mode, 0x0C and 0x06

module char_lcd_bus_sequencer
    import lcdseq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // opcode[1:0], value[9:2], row_base[17:10], column[24:18]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // rs_level[0], en_level[1], data_lines[9:2], hold_ms[16:10]
    output logic                 m_tlast    // last_step
);

    job_t  front_job;
    cfg_t  cfg;
    logic  q_valid;
    logic  q_pop;
    job_t  q_job;
    step_t step;

    lcdseq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (s_tdata),
        .job       (front_job),
        .cfg       (cfg)
    );

    lcdseq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid && s_tready),
        .push_job  (front_job),
        .in_ready  (s_tready),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_job   (q_job)
    );

    lcdseq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_step  (step)
    );

    // output packing
    assign m_tdata = {7'd0, step.hold, step.data, step.en, step.rs};
    assign m_tlast = step.last;

endmodule

// ===== hw/rtl/lcdseq_checker.sv =====
`timescale 1ns / 1ps

module lcdseq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // a stalled step holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output step changed while stalled");

    // every step holds at least one millisecond
    a_hold_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[16:10] != 7'd0)
        else $error("zero hold time");

    // an enable pulse is followed at once by its falling step
    a_en_fall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tdata[1] |=> m_tvalid && !m_tdata[1])
        else $error("enable high not followed by enable low");

    // a request ends with enable low and the long settle hold
    a_last_settle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tdata[1] && m_tdata[16:10] >= 7'd101)
        else $error("bad final step");

endmodule

bind char_lcd_bus_sequencer lcdseq_checker u_lcdseq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
